// ===== sv/evp_pkg.sv =====
// evp_pkg: widths, register indexes, constants, unit request/response types and
// sequencer states of the encoder velocity PID block.
// No dependencies; compile first.
package evp_pkg;

  // Field widths
  localparam int POS_W    = 32;
  localparam int TIME_W   = 32;
  localparam int VEL_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int CPR_W    = 16;
  localparam int DRIVE_W  = 8;
  localparam int INTEG_W  = 48;
  localparam int DERIV_W  = 44;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CPR    = 3'd4;

  localparam logic [CPR_W-1:0] CPR_RESET = 16'd360;

  // Serial unit widths
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = 64;
  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 48;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = 6;

  // round(2*pi*1000*65536)
  localparam logic [MUL_B_W-1:0] TWO_PI_KILO = 32'd411774832;
  localparam logic [MUL_B_W-1:0] KILO_B      = 32'd1000;
  localparam logic [DIV_D_W-1:0] KILO_D      = 48'd1000;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] q;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEN,
    S_NUM,
    S_VEL,
    S_ERR,
    S_INC_MUL,
    S_INC_DIV,
    S_DIF_MUL,
    S_DER_DIV,
    S_P_MUL,
    S_I_MUL,
    S_D_MUL,
    S_OUT
  } evp_state_t;

endpackage

// ===== sv/evp_if.sv =====
// evp_if: valid/ready channel interfaces for sample items and result items.
// Depends on evp_pkg for field widths.
interface evp_in_if;
  import evp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  encoder_position;
  logic        [TIME_W-1:0] time_ms;

  modport source (output valid, output encoder_position, output time_ms, input ready);
  modport sink   (input valid, input encoder_position, input time_ms, output ready);
endinterface

interface evp_out_if;
  import evp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [DRIVE_W-1:0] drive;
  logic signed [VEL_W-1:0]   velocity;
  logic signed [VEL_W-1:0]   error_value;

  modport source (output valid, output drive, output velocity, output error_value,
                  input ready);
  modport sink   (input valid, input drive, input velocity, input error_value,
                  output ready);
endinterface

// ===== sv/evp_mul.sv =====
// evp_mul: unsigned shift-and-add multiplier, one multiplier bit per cycle.
// Runs until the remaining multiplier bits are zero. Depends on evp_pkg.
module evp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  evp_pkg::mul_req_t req,
  output evp_pkg::mul_rsp_t rsp
);
  import evp_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [PROD_W-1:0]  m_r, m_nxt;
  logic [PROD_W-1:0]  p_r, p_nxt;
  logic [MUL_B_W-1:0] b_r, b_nxt;

  // one partial product per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    m_nxt    = m_r;
    p_nxt    = p_r;
    b_nxt    = b_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      m_nxt    = PROD_W'(req.a);
      p_nxt    = '0;
      b_nxt    = req.b;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) p_nxt = p_r + m_r;
        m_nxt = {m_r[PROD_W-2:0], 1'b0};
        b_nxt = {1'b0, b_r[MUL_B_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
    p_r <= p_nxt;
    b_r <= b_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

// ===== sv/evp_div.sv =====
// evp_div: unsigned restoring divider, one quotient bit per cycle, fixed step count.
// Depends on evp_pkg. A zero divisor yields an all-ones quotient.
module evp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  evp_pkg::div_req_t req,
  output evp_pkg::div_rsp_t rsp
);
  import evp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_D_W-1:0]   d_r, d_nxt;
  logic [DIV_N_W-1:0]   q_r, q_nxt;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  // shift one dividend bit into the remainder, subtract if it fits
  always_comb begin
    trial    = {rem_r, q_r[DIV_N_W-1]};
    fits     = (trial >= {1'b0, d_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_nxt  = '0;
      d_nxt    = req.d;
      q_nxt    = req.n;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_D_W'(trial - {1'b0, d_r}) : trial[DIV_D_W-1:0];
      q_nxt   = {q_r[DIV_N_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

// ===== sv/encoder_velocity_pid.sv =====
// Encoder velocity estimator and PID speed controller. Each sample item (encoder count
// and millisecond timestamp) yields one result item: drive 0..255, velocity and error
// in Q16.16 rad/s. One item is in work at a time, worked through serial arithmetic: three
// 64-step restoring divisions (velocity, integral increment, derivative) plus shift-and-add
// multiplies whose length follows the bit length of the multiplier (counts per rev, the
// 29-bit 2*pi*1000 constant, |error|, 1000 and the three gains). The next item is
// accepted the cycle after a result is loaded into the output register, even while that
// result waits. The user must write configuration only while the block is idle; the
// block itself does not enforce this.
// Depends on evp_pkg, evp_if, evp_mul and evp_div.
module encoder_velocity_pid (
  input  logic                              clk,
  input  logic                              rst_n,
  evp_in_if.sink                            in_ch,
  evp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [evp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [evp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import evp_pkg::*;

  // configuration registers
  logic [VEL_W-1:0]  tgt_r;
  logic [GAIN_W-1:0] gp_r, gi_r, gd_r;
  logic [CPR_W-1:0]  cpr_r;

  // controller state
  logic [POS_W-1:0]   last_pos_r, last_pos_nxt;
  logic [TIME_W-1:0]  last_time_r, last_time_nxt;
  logic [INTEG_W-1:0] integ_r, integ_nxt;
  logic [VEL_W-1:0]   prev_err_r, prev_err_nxt;

  // sequencer
  evp_state_t state_r, state_nxt;
  logic       launched_r, launched_nxt;

  // working registers
  logic [TIME_W-1:0]  dt_r, dt_nxt;
  logic [POS_W-1:0]   dpos_mag_r, dpos_mag_nxt;
  logic               dpos_neg_r, dpos_neg_nxt;
  logic [DIV_D_W-1:0] den_r, den_nxt;
  logic [VEL_W-1:0]   vel_r, vel_nxt;
  logic [VEL_W-1:0]   err_r, err_nxt;
  logic [DERIV_W-1:0] deriv_r, deriv_nxt;
  logic [PROD_W-1:0]  sum_r, sum_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] out_drive_r, out_drive_nxt;
  logic [VEL_W-1:0]   out_vel_r, out_vel_nxt;
  logic [VEL_W-1:0]   out_err_r, out_err_nxt;

  // unit handshakes
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     mul_state, div_state, op_done;
  logic     in_acc, out_load;

  // derived operands
  logic [TIME_W-1:0]  dt_in;
  logic [POS_W-1:0]   dpos_in;
  logic               dt_zero;
  logic [CPR_W-1:0]   cpr_eff;
  logic [VEL_W-1:0]   err_mag;
  logic [VEL_W:0]     diff;
  logic [VEL_W:0]     diff_mag;
  logic [GAIN_W-1:0]  gp_mag, gi_mag, gd_mag;
  logic [INTEG_W-1:0] integ_mag;
  logic [DERIV_W-1:0] deriv_mag;
  logic [VEL_W:0]     err_wide;
  logic [56:0]        inc_w, inc_s, integ_s;
  logic [DERIV_W-1:0] dm;
  logic               term_neg;
  logic [PROD_W-1:0]  term;

  evp_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  evp_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_acc = in_ch.valid && in_ch.ready;

  // operand preparation
  always_comb begin
    dt_in     = in_ch.time_ms - last_time_r;
    dpos_in   = in_ch.encoder_position - last_pos_r;
    dt_zero   = (dt_r == '0);
    cpr_eff   = (cpr_r == '0) ? CPR_W'(1) : cpr_r;
    err_mag   = err_r[VEL_W-1] ? (~err_r + 1'b1) : err_r;
    diff      = {err_r[VEL_W-1], err_r} - {prev_err_r[VEL_W-1], prev_err_r};
    diff_mag  = diff[VEL_W] ? (~diff + 1'b1) : diff;
    gp_mag    = gp_r[GAIN_W-1] ? (~gp_r + 1'b1) : gp_r;
    gi_mag    = gi_r[GAIN_W-1] ? (~gi_r + 1'b1) : gi_r;
    gd_mag    = gd_r[GAIN_W-1] ? (~gd_r + 1'b1) : gd_r;
    integ_mag = integ_r[INTEG_W-1] ? (~integ_r + 1'b1) : integ_r;
    deriv_mag = deriv_r[DERIV_W-1] ? (~deriv_r + 1'b1) : deriv_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_acc) state_nxt = S_DEN;
      S_DEN:     if (mul_rsp.done) state_nxt = S_NUM;
      S_NUM:     if (mul_rsp.done) state_nxt = S_VEL;
      S_VEL:     if (div_rsp.done) state_nxt = S_ERR;
      S_ERR:     state_nxt = S_INC_MUL;
      S_INC_MUL: if (mul_rsp.done) state_nxt = S_INC_DIV;
      S_INC_DIV: if (div_rsp.done) state_nxt = S_DIF_MUL;
      S_DIF_MUL: if (mul_rsp.done) state_nxt = S_DER_DIV;
      S_DER_DIV: if (div_rsp.done) state_nxt = S_P_MUL;
      S_P_MUL:   if (mul_rsp.done) state_nxt = S_I_MUL;
      S_I_MUL:   if (mul_rsp.done) state_nxt = S_D_MUL;
      S_D_MUL:   if (mul_rsp.done) state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: unit requests and handshakes
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
    mul_state   = 1'b0;
    div_state   = 1'b0;
    mul_req     = '0;
    div_req     = '0;
    case (state_r)
      S_DEN: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(dt_r);
        mul_req.b = MUL_B_W'(cpr_eff);
      end
      S_NUM: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(dpos_mag_r);
        mul_req.b = TWO_PI_KILO;
      end
      S_VEL: begin
        div_state = 1'b1;
        div_req.n = mul_rsp.p;
        div_req.d = den_r;
      end
      S_INC_MUL: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(dt_r);
        mul_req.b = err_mag;
      end
      S_INC_DIV: begin
        div_state = 1'b1;
        div_req.n = mul_rsp.p;
        div_req.d = KILO_D;
      end
      S_DIF_MUL: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(diff_mag);
        mul_req.b = KILO_B;
      end
      S_DER_DIV: begin
        div_state = 1'b1;
        div_req.n = mul_rsp.p;
        div_req.d = DIV_D_W'(dt_r);
      end
      S_P_MUL: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(err_mag);
        mul_req.b = MUL_B_W'(gp_mag);
      end
      S_I_MUL: begin
        mul_state = 1'b1;
        mul_req.a = integ_mag;
        mul_req.b = MUL_B_W'(gi_mag);
      end
      S_D_MUL: begin
        mul_state = 1'b1;
        mul_req.a = MUL_A_W'(deriv_mag);
        mul_req.b = MUL_B_W'(gd_mag);
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    mul_req.start = mul_state && !launched_r;
    div_req.start = div_state && !launched_r;
  end

  // datapath next values
  always_comb begin
    last_pos_nxt  = last_pos_r;
    last_time_nxt = last_time_r;
    integ_nxt     = integ_r;
    prev_err_nxt  = prev_err_r;
    dt_nxt        = dt_r;
    dpos_mag_nxt  = dpos_mag_r;
    dpos_neg_nxt  = dpos_neg_r;
    den_nxt       = den_r;
    vel_nxt       = vel_r;
    err_nxt       = err_r;
    deriv_nxt     = deriv_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_drive_nxt = out_drive_r;
    out_vel_nxt   = out_vel_r;
    out_err_nxt   = out_err_r;

    op_done      = mul_state ? mul_rsp.done : div_rsp.done;
    launched_nxt = (mul_state || div_state) && !op_done;

    err_wide = {tgt_r[VEL_W-1], tgt_r} - {vel_r[VEL_W-1], vel_r};
    inc_w    = {3'b000, div_rsp.q[53:0]};
    inc_s    = err_r[VEL_W-1] ? (~inc_w + 1'b1) : inc_w;
    integ_s  = {{9{integ_r[INTEG_W-1]}}, integ_r} + inc_s;
    dm       = {1'b0, div_rsp.q[DERIV_W-2:0]};
    case (state_r)
      S_P_MUL: term_neg = err_r[VEL_W-1] ^ gp_r[GAIN_W-1];
      S_I_MUL: term_neg = integ_r[INTEG_W-1] ^ gi_r[GAIN_W-1];
      default: term_neg = deriv_r[DERIV_W-1] ^ gd_r[GAIN_W-1];
    endcase
    term = term_neg ? (~mul_rsp.p + 1'b1) : mul_rsp.p;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dt_nxt        = dt_in;
          dpos_neg_nxt  = dpos_in[POS_W-1];
          dpos_mag_nxt  = dpos_in[POS_W-1] ? (~dpos_in + 1'b1) : dpos_in;
          last_pos_nxt  = in_ch.encoder_position;
          last_time_nxt = in_ch.time_ms;
        end
      end
      S_DEN: begin
        if (mul_rsp.done) den_nxt = mul_rsp.p[DIV_D_W-1:0];
      end
      // quotient magnitude saturates at 2^31, then clamps to the signed range
      S_VEL: begin
        if (div_rsp.done) begin
          if (dt_zero) begin
            vel_nxt = '0;
          end else if (|div_rsp.q[DIV_N_W-1:VEL_W-1]) begin
            vel_nxt = dpos_neg_r ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
          end else begin
            vel_nxt = dpos_neg_r ? (~div_rsp.q[VEL_W-1:0] + 1'b1) : div_rsp.q[VEL_W-1:0];
          end
        end
      end
      S_ERR: begin
        if (err_wide[VEL_W] != err_wide[VEL_W-1]) begin
          err_nxt = err_wide[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
          err_nxt = err_wide[VEL_W-1:0];
        end
      end
      // integral update, saturated to 48 bits signed
      S_INC_DIV: begin
        if (div_rsp.done && !dt_zero) begin
          if ((integ_s[56:INTEG_W-1] == '0) || (integ_s[56:INTEG_W-1] == '1)) begin
            integ_nxt = integ_s[INTEG_W-1:0];
          end else begin
            integ_nxt = integ_s[56] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                    : {1'b0, {(INTEG_W-1){1'b1}}};
          end
        end
      end
      S_DER_DIV: begin
        if (div_rsp.done) begin
          if (dt_zero) deriv_nxt = '0;
          else         deriv_nxt = diff[VEL_W] ? (~dm + 1'b1) : dm;
        end
      end
      S_P_MUL: begin
        if (mul_rsp.done) sum_nxt = term;
      end
      S_I_MUL, S_D_MUL: begin
        if (mul_rsp.done) sum_nxt = sum_r + term;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_vel_nxt   = vel_r;
          out_err_nxt   = err_r;
          prev_err_nxt  = err_r;
          if (sum_r[PROD_W-1])      out_drive_nxt = '0;
          else if (|sum_r[62:32])   out_drive_nxt = '1;
          else                      out_drive_nxt = sum_r[31:24];
        end
      end
      default: begin
        sum_nxt = sum_r;
      end
    endcase
  end

  // control, configuration and controller state, with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tgt_r       <= '0;
      gp_r        <= '0;
      gi_r        <= '0;
      gd_r        <= '0;
      cpr_r       <= CPR_RESET;
      last_pos_r  <= '0;
      last_time_r <= '0;
      integ_r     <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
      last_pos_r  <= last_pos_nxt;
      last_time_r <= last_time_nxt;
      integ_r     <= integ_nxt;
      prev_err_r  <= prev_err_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: tgt_r <= cfg_wdata[VEL_W-1:0];
          REG_GAIN_P: gp_r  <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_I: gi_r  <= cfg_wdata[GAIN_W-1:0];
          REG_GAIN_D: gd_r  <= cfg_wdata[GAIN_W-1:0];
          REG_CPR:    cpr_r <= cfg_wdata[CPR_W-1:0];
          default:    tgt_r <= tgt_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dt_r        <= dt_nxt;
    dpos_mag_r  <= dpos_mag_nxt;
    dpos_neg_r  <= dpos_neg_nxt;
    den_r       <= den_nxt;
    vel_r       <= vel_nxt;
    err_r       <= err_nxt;
    deriv_r     <= deriv_nxt;
    sum_r       <= sum_nxt;
    out_drive_r <= out_drive_nxt;
    out_vel_r   <= out_vel_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive       = out_drive_r;
  assign out_ch.velocity    = out_vel_r;
  assign out_ch.error_value = out_err_r;

`ifndef SYNTHESIS
  // the two serial units are never launched together
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_req.start && div_req.start))
    else $error("multiplier and divider started in the same cycle");

  // a multiplier result only lands in a state that waits for it
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> (state_r == S_DEN || state_r == S_NUM || state_r == S_INC_MUL ||
                      state_r == S_DIF_MUL || state_r == S_P_MUL || state_r == S_I_MUL ||
                      state_r == S_D_MUL))
    else $error("multiplier done outside a multiply step");

  // a divider result only lands in a state that waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_VEL || state_r == S_INC_DIV || state_r == S_DER_DIV))
    else $error("divider done outside a divide step");

  // a result item appears only out of the output step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result valid raised outside the output step");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for encoder_velocity_pid, directed table then random
// sample items under several register settings, results checked vs table or predictor.
// Depends on evp_pkg, evp_if and the encoder_velocity_pid RTL.
module testbench;
  import evp_pkg::*;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [VEL_W-1:0]   velocity;
    logic [VEL_W-1:0]   error_value;
  } pid_out_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] a;      // encoder position, or register index
    logic [31:0] b;      // timestamp, or write data
    bit          typed;  // result given in the row
    pid_out_t    want;
  } dir_row_t;

  // Indexes past the last register; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int     NUM_PHASES      = 6;
  localparam int     ITEMS_PER_PHASE = 75;
  localparam int     STALL_LIMIT     = 4000;
  localparam int     DRAIN_CYCLES    = 400;
  localparam int     MAX_REPORTS     = 100;
  localparam longint VEL_MAX         = 64'sd2147483647;
  localparam longint VEL_MIN         = -64'sd2147483648;
  localparam longint INTEG_MAX       = (64'sd1 <<< 47) - 64'sd1;
  localparam longint INTEG_MIN       = -(64'sd1 <<< 47);
  localparam pid_out_t NO_RESULT     = '0;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  evp_in_if  in_ch ();
  evp_out_if out_ch ();

  encoder_velocity_pid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies
  logic signed [31:0] tgt_q;
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic        [15:0] cpr_q;

  // Controller state copies
  logic [31:0] prev_pos_q;
  logic [31:0] prev_time_q;
  longint      integral_q;
  longint      prev_err_q;

  pid_out_t    expected_results[$];
  dir_row_t    dir_rows[$];
  int          fail_count;
  int          stall_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [31:0] last_pos;
  logic [31:0] last_time_sent;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] mag_of(input longint v);
    if (v < 0) return -v;
    return v;
  endfunction

  function automatic longint signed_of(input logic [63:0] m, input bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_s64(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // One control step: velocity estimate, error, integral, derivative, drive
  function automatic pid_out_t predict_pid(input logic [31:0] pos, input logic [31:0] now);
    logic [31:0]        dt;
    logic signed [31:0] dpos;
    logic [63:0]        cpr, q, inc, dm;
    longint             vel, err, diff, deriv, sum;
    pid_out_t           res;
    dt   = now - prev_time_q;
    dpos = pos - prev_pos_q;
    cpr  = (cpr_q == '0) ? 64'd1 : 64'(cpr_q);   // zero counts per rev acts as one
    vel   = 0;
    deriv = 0;
    if (dt != 0) begin
      q = (mag_of(dpos) * 64'(TWO_PI_KILO)) / (cpr * 64'(dt));
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      vel = clamp_s64(signed_of(q, dpos < 0), VEL_MIN, VEL_MAX);
    end
    err = clamp_s64(longint'(tgt_q) - vel, VEL_MIN, VEL_MAX);
    // zero time delta leaves the integral alone and zeroes the derivative
    if (dt != 0) begin
      inc        = (mag_of(err) * 64'(dt)) / 64'd1000;
      diff       = err - prev_err_q;
      dm         = (mag_of(diff) * 64'd1000) / 64'(dt);
      integral_q = clamp_s64(integral_q + signed_of(inc, err < 0), INTEG_MIN, INTEG_MAX);
      deriv      = signed_of(dm, diff < 0);
    end
    sum = longint'(kp_q) * err + longint'(ki_q) * integral_q + longint'(kd_q) * deriv;
    if (sum < 0) begin
      res.drive = '0;
    end else if ((sum >>> 24) > 255) begin
      res.drive = 8'd255;
    end else begin
      res.drive = 8'(sum >>> 24);
    end
    res.velocity    = 32'(vel);
    res.error_value = 32'(err);
    prev_err_q  = err;
    prev_pos_q  = pos;
    prev_time_q = now;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table building
  // ---------------------------------------------------------------------------
  function automatic void add_sample(input logic [31:0] pos, input logic [31:0] t);
    dir_rows.push_back('{ROW_SAMPLE, pos, t, 1'b0, NO_RESULT});
  endfunction

  function automatic void add_checked(input logic [31:0] pos, input logic [31:0] t,
                                      input pid_out_t want);
    dir_rows.push_back('{ROW_SAMPLE, pos, t, 1'b1, want});
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    dir_rows.push_back('{ROW_WRITE, 32'(idx), data, 1'b0, NO_RESULT});
  endfunction

  function automatic void set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 14;
        recv_idle_pct = 50;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 50;
        recv_idle_pct = 14;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    // keep the log short when everything goes wrong
    if (fail_count <= MAX_REPORTS)
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Register write, only once every pending result is back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_TARGET: tgt_q = data;
      REG_GAIN_P: kp_q  = data[15:0];
      REG_GAIN_I: ki_q  = data[15:0];
      REG_GAIN_D: kd_q  = data[15:0];
      REG_CPR:    cpr_q = data[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // One sample item; valid stays high on return so back-to-back items need no gap
  task automatic send_sample(input logic [31:0] pos, input logic [31:0] t, input bit typed,
                             input pid_out_t want);
    pid_out_t predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.encoder_position <= pos;
    in_ch.time_ms          <= t;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_pid(pos, t);
    expected_results.push_back(typed ? want : predicted);
    last_pos       = pos;
    last_time_sent = t;
    @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pid_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", out_ch.velocity, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.drive !== want.drive)
          report_mismatch("drive", {24'd0, out_ch.drive}, {24'd0, want.drive});
        if (out_ch.velocity !== want.velocity)
          report_mismatch("velocity", out_ch.velocity, want.velocity);
        if (out_ch.error_value !== want.error_value)
          report_mismatch("error_value", out_ch.error_value, want.error_value);
      end
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          r;
    int          tgt;
    logic [31:0] nxt_pos;
    logic [31:0] nxt_time;

    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.encoder_position = '0;
    in_ch.time_ms          = '0;
    out_ch.ready           = 1'b0;
    fail_count             = 0;
    stall_cycles           = 0;
    last_pos               = '0;
    last_time_sent         = '0;
    tgt_q                  = '0;
    kp_q                   = '0;
    ki_q                   = '0;
    kd_q                   = '0;
    cpr_q                  = CPR_RESET;
    prev_pos_q             = '0;
    prev_time_q            = '0;
    integral_q             = 0;
    prev_err_q             = 0;
    set_idling(IDLE_SEND_LIGHT);

    // after reset: zero gains and target, 360 counts per rev
    add_checked(32'd0,   32'd0,    {8'd0, 32'd0, 32'd0});
    add_checked(32'd0,   32'd0,    {8'd0, 32'd0, 32'd0});          // zero time delta
    add_checked(32'd360, 32'd1000, {8'd0, 32'd411774, -32'sd411774});
    add_checked(32'd360, 32'd1000, {8'd0, 32'd0, 32'd0});          // zero time delta
    // zero counts per rev, unit gain, top target, dropped writes
    add_write(REG_CPR, 32'hABCD_0000);
    add_write(REG_GAIN_P, 32'h0000_0100);
    add_write(REG_TARGET, 32'h7FFF_FFFF);
    add_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    add_write(REG_SPARE_HI, 32'h0000_0000);
    add_sample(32'h7FFF_FFFF, 32'd1001);      // velocity saturates high
    add_sample(32'h0000_0000, 32'd1002);
    add_sample(32'h8000_0000, 32'd1003);      // most negative delta, error saturates
    add_sample(32'h8000_0000, 32'hFFFF_FFFF); // huge dt, integral saturates
    add_sample(32'h8000_0005, 32'd4);         // timestamp wraps
    // gain and register extremes
    add_write(REG_GAIN_P, 32'h5555_7FFF);
    add_write(REG_GAIN_I, 32'hAAAA_7FFF);
    add_write(REG_GAIN_D, 32'hFFFF_8000);
    add_write(REG_TARGET, 32'h8000_0000);
    add_write(REG_CPR, 32'h0000_FFFF);
    add_sample(32'hFFFF_FFFF, 32'd10);
    add_sample(32'h7FFF_FFFF, 32'd10);
    add_sample(32'h1234_5678, 32'hFFFF_0000);
    add_sample(32'hEDCB_A987, 32'h0000_FFFF);
    // opposite extremes, then a gentle run at 100 rad/s
    add_write(REG_GAIN_P, 32'h0000_8000);
    add_write(REG_GAIN_I, 32'h0000_8000);
    add_write(REG_GAIN_D, 32'h0000_7FFF);
    add_write(REG_TARGET, 32'h0064_0000);
    add_write(REG_CPR, 32'd360);
    add_sample(32'd10, 32'h0001_0005);
    add_sample(32'd20, 32'h0001_000A);
    add_sample(32'd15, 32'h0001_000F);
    add_sample(32'd15, 32'h0001_0014);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].a[CFG_IDX_W-1:0], dir_rows[i].b);
      end else begin
        send_sample(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each with its own register setting; each pair of phases shares an idling mode
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idling(idle_mode_t'(p / 2));
      case (p)
        1: begin
          write_reg(REG_TARGET, 32'h7FFF_FFFF);
          write_reg(REG_GAIN_P, {16'($urandom()), 16'h7FFF});
          write_reg(REG_GAIN_I, {16'($urandom()), 16'h7FFF});
          write_reg(REG_GAIN_D, {16'($urandom()), 16'h7FFF});
          write_reg(REG_CPR, {16'($urandom()), 16'hFFFF});
        end
        2: begin
          write_reg(REG_TARGET, 32'h8000_0000);
          write_reg(REG_GAIN_P, {16'($urandom()), 16'h8000});
          write_reg(REG_GAIN_I, {16'($urandom()), 16'h8000});
          write_reg(REG_GAIN_D, {16'($urandom()), 16'h8000});
          write_reg(REG_CPR, {16'($urandom()), 16'h0001});
        end
        default: begin
          // targets within +-200 rad/s, gains around unity so drive lands mid-range
          tgt = int'($urandom_range(0, 400 * 65536)) - 200 * 65536;
          write_reg(REG_TARGET, tgt);
          write_reg(REG_GAIN_P, {16'($urandom()), 16'(int'($urandom_range(0, 1536)) - 512)});
          write_reg(REG_GAIN_I, {16'($urandom()), 16'(int'($urandom_range(0, 64)) - 16)});
          write_reg(REG_GAIN_D, {16'($urandom()), 16'(int'($urandom_range(0, 64)) - 32)});
          write_reg(REG_CPR, {16'($urandom()),
                              ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4096))});
        end
      endcase

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          // steady motion: small count deltas over a few ms
          nxt_time = last_time_sent + $urandom_range(1, 50);
          nxt_pos  = last_pos + $urandom_range(0, 60) - 32'd30;
        end else if (r < 88) begin
          // repeated timestamp
          nxt_time = last_time_sent;
          nxt_pos  = last_pos + $urandom_range(0, 200) - 32'd100;
        end else if (r < 95) begin
          nxt_time = $urandom();
          nxt_pos  = $urandom();
        end else begin
          nxt_time = last_time_sent + $urandom_range(1000, 1 << 20);
          nxt_pos  = $urandom();
        end
        send_sample(nxt_pos, nxt_time, 1'b0, NO_RESULT);
      end
    end

    in_ch.valid <= 1'b0;
    cfg_we      <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
